/* rtl/tpf_pkg.sv */
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants and codes for the touch point filter.
// ----------------------------------------------------------------------------
package tpf_pkg;

  // field widths fixed by the interface
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned READ_W  = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned PHASE_W = 2;

  // APB register map (index = paddr / 4)
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_X_GAIN       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_SHIFT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_GAIN       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_SHIFT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_AGREE_WINDOW = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd7;

  // reset values
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST    = 12'd100;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = 12'd4000;
  localparam logic [LIMIT_W-1:0] AGREE_WINDOW_RST = 12'd50;
  localparam logic [CNT_W-1:0]   MAX_ATTEMPTS_RST = 4'd10;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_PENDING     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_READY       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAILED      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_TOUCHED = 2'd3;

  // read sequence
  localparam logic [PHASE_W-1:0] PH_X1 = 2'd0;
  localparam logic [PHASE_W-1:0] PH_Y1 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_X2 = 2'd2;
  localparam logic [PHASE_W-1:0] PH_Y2 = 2'd3;

endpackage

/* rtl/touch_point_filter_unit.sv */
// ----------------------------------------------------------------------------
// touch_point_filter_unit
// Best-two-of-three touch filter with X/Y/X/Y agreement check and calibration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries three raw conversions of one
//   axis plus pen_down. Feed axes in the order shown by next_axis of the
//   previous result (X, Y, X, Y). Every item gives exactly one result on the
//   output channel (out_valid / out_stall): status, next_axis, point_x/y.
//   point_x/y are nonzero only when status reports a ready point.
// Timing:
//   Four register stages: input capture, best-two filter, sequence/agreement
//   check (owns the read history), calibration multiply. One item per cycle
//   sustained while out_stall is low.
// Stalls:
//   out_stall freezes the whole pipe; in_stall rises once all stages hold
//   items. Stages with bubbles keep moving, so up to four items buffer.
// Reset:
//   rst (synchronous) empties the pipe, restarts the sequence at first X,
//   clears the attempt count and loads the register defaults (gains and
//   offsets 0, limits 100..4000, agree window 50, max attempts 10).
// Registers (APB, byte address 4*i): x_gain, x_shift, y_gain, y_shift,
//   low_limit, high_limit, agree_window, max_attempts. Write only while idle.
// ----------------------------------------------------------------------------
module touch_point_filter_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpf_pkg::PADDR_W-1:0]    paddr,
  input  logic [tpf_pkg::PDATA_W-1:0]    pwdata,
  output logic [tpf_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         sample_first,
  input  logic [SAMPLE_BITS-1:0]         sample_second,
  input  logic [SAMPLE_BITS-1:0]         sample_third,
  input  logic                           pen_down,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tpf_pkg::STAT_W-1:0]     status,
  output logic                           next_axis,
  output logic [tpf_pkg::COORD_W-1:0]    point_x,
  output logic [tpf_pkg::COORD_W-1:0]    point_y
);

  // compare width covering both samples and 12-bit limits
  localparam int unsigned CMP_W = (SAMPLE_BITS > tpf_pkg::LIMIT_W) ?
                                  SAMPLE_BITS : tpf_pkg::LIMIT_W;
  localparam int unsigned MUL_W = 2 * tpf_pkg::GAIN_W;

  // ---------------- configuration registers ----------------
  logic [tpf_pkg::GAIN_W-1:0]  x_gain, x_shift, y_gain, y_shift;
  logic [tpf_pkg::LIMIT_W-1:0] low_limit, high_limit, agree_window;
  logic [tpf_pkg::CNT_W-1:0]   max_attempts;
  logic                        cfg_wr;
  logic [tpf_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[tpf_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_gain       <= '0;
      x_shift      <= '0;
      y_gain       <= '0;
      y_shift      <= '0;
      low_limit    <= tpf_pkg::LOW_LIMIT_RST;
      high_limit   <= tpf_pkg::HIGH_LIMIT_RST;
      agree_window <= tpf_pkg::AGREE_WINDOW_RST;
      max_attempts <= tpf_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tpf_pkg::REG_X_GAIN:       x_gain       <= pwdata[tpf_pkg::GAIN_W-1:0];
        tpf_pkg::REG_X_SHIFT:      x_shift      <= pwdata[tpf_pkg::GAIN_W-1:0];
        tpf_pkg::REG_Y_GAIN:       y_gain       <= pwdata[tpf_pkg::GAIN_W-1:0];
        tpf_pkg::REG_Y_SHIFT:      y_shift      <= pwdata[tpf_pkg::GAIN_W-1:0];
        tpf_pkg::REG_LOW_LIMIT:    low_limit    <= pwdata[tpf_pkg::LIMIT_W-1:0];
        tpf_pkg::REG_HIGH_LIMIT:   high_limit   <= pwdata[tpf_pkg::LIMIT_W-1:0];
        tpf_pkg::REG_AGREE_WINDOW: agree_window <= pwdata[tpf_pkg::LIMIT_W-1:0];
        tpf_pkg::REG_MAX_ATTEMPTS: max_attempts <= pwdata[tpf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      tpf_pkg::REG_X_GAIN:       prdata = 32'(x_gain);
      tpf_pkg::REG_X_SHIFT:      prdata = 32'(x_shift);
      tpf_pkg::REG_Y_GAIN:       prdata = 32'(y_gain);
      tpf_pkg::REG_Y_SHIFT:      prdata = 32'(y_shift);
      tpf_pkg::REG_LOW_LIMIT:    prdata = 32'(low_limit);
      tpf_pkg::REG_HIGH_LIMIT:   prdata = 32'(high_limit);
      tpf_pkg::REG_AGREE_WINDOW: prdata = 32'(agree_window);
      tpf_pkg::REG_MAX_ATTEMPTS: prdata = 32'(max_attempts);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  // stage 1: input capture, stage 2: filtered value,
  // stage 3: sequence decision, stage 4: output register
  logic v1, v2, v3;
  logic en1, en2, en3, en_o;

  assign en_o     = ~out_valid | ~out_stall;
  assign en3      = ~v3 | en_o;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign in_stall = ~en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1        <= in_valid;
      if (en2)  v2        <= v1;
      if (en3)  v3        <= v2;
      if (en_o) out_valid <= v3;
    end
  end

  // ---------------- stage 1: capture ----------------
  logic [SAMPLE_BITS-1:0] s1_a, s1_b, s1_c;
  logic                   s1_pen;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a   <= sample_first;
      s1_b   <= sample_second;
      s1_c   <= sample_third;
      s1_pen <= pen_down;
    end
  end

  // ---------------- stage 2: best two of three ----------------
  logic [SAMPLE_BITS-1:0] d_ab, d_ac, d_bc;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [SAMPLE_BITS-1:0] s2_val;
  logic                   s2_pen;

  assign d_ab = (s1_a > s1_b) ? s1_a - s1_b : s1_b - s1_a;
  assign d_ac = (s1_a > s1_c) ? s1_a - s1_c : s1_c - s1_a;
  assign d_bc = (s1_b > s1_c) ? s1_b - s1_c : s1_c - s1_b;

  always_comb begin
    priority if (d_ab <= d_ac && d_ab <= d_bc) begin
      pair_sum = {1'b0, s1_a} + {1'b0, s1_b};
    end else if (d_ac <= d_bc) begin
      pair_sum = {1'b0, s1_a} + {1'b0, s1_c};
    end else begin
      pair_sum = {1'b0, s1_b} + {1'b0, s1_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_val <= pair_sum[SAMPLE_BITS:1];
      s2_pen <= s1_pen;
    end
  end

  // ---------------- stage 3: sequence and agreement ----------------
  logic [tpf_pkg::PHASE_W-1:0] phase, phase_next;
  logic [tpf_pkg::CNT_W-1:0]   attempt_count, attempt_next, attempt_inc;
  logic [tpf_pkg::READ_W-1:0]  first_x_read, first_y_read, second_x_read;
  logic [tpf_pkg::READ_W-1:0]  val_rd;
  logic [CMP_W-1:0]            val_cmp;
  logic                        in_window, failed, agree;
  logic [tpf_pkg::READ_W-1:0]  dx, dy;
  logic [tpf_pkg::READ_W:0]    sum_x, sum_y;
  logic [tpf_pkg::STAT_W-1:0]  stat_next;
  logic                        upd;

  logic [tpf_pkg::STAT_W-1:0]  s3_status;
  logic                        s3_axis;
  logic [tpf_pkg::READ_W-1:0]  s3_avg_x, s3_avg_y;

  assign upd       = v2 & en3;
  assign val_cmp   = CMP_W'(s2_val);
  assign val_rd    = tpf_pkg::READ_W'(s2_val);
  assign in_window = (val_cmp >= CMP_W'(low_limit)) && (val_cmp <= CMP_W'(high_limit));
  assign dx = (first_x_read > second_x_read) ? first_x_read - second_x_read
                                             : second_x_read - first_x_read;
  assign dy = (first_y_read > val_rd) ? first_y_read - val_rd : val_rd - first_y_read;
  assign agree       = (dx < agree_window) && (dy < agree_window);
  assign sum_x       = {1'b0, first_x_read} + {1'b0, second_x_read};
  assign sum_y       = {1'b0, first_y_read} + {1'b0, val_rd};
  assign attempt_inc = attempt_count + 1'b1;

  always_comb begin
    phase_next   = phase;
    attempt_next = attempt_count;
    stat_next    = tpf_pkg::STAT_PENDING;
    failed       = 1'b0;
    if (!s2_pen) begin
      phase_next   = tpf_pkg::PH_X1;
      attempt_next = '0;
      stat_next    = tpf_pkg::STAT_NOT_TOUCHED;
    end else if (!in_window) begin
      failed = 1'b1;
    end else begin
      unique case (phase)
        tpf_pkg::PH_X1: phase_next = tpf_pkg::PH_Y1;
        tpf_pkg::PH_Y1: phase_next = tpf_pkg::PH_X2;
        tpf_pkg::PH_X2: phase_next = tpf_pkg::PH_Y2;
        tpf_pkg::PH_Y2: begin
          if (agree) begin
            phase_next   = tpf_pkg::PH_X1;
            attempt_next = '0;
            stat_next    = tpf_pkg::STAT_READY;
          end else begin
            failed = 1'b1;
          end
        end
        default: phase_next = tpf_pkg::PH_X1;
      endcase
    end
    if (failed) begin
      phase_next = tpf_pkg::PH_X1;
      if (attempt_inc >= max_attempts) begin
        attempt_next = '0;
        stat_next    = tpf_pkg::STAT_FAILED;
      end else begin
        attempt_next = attempt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tpf_pkg::PH_X1;
      attempt_count <= '0;
      first_x_read  <= '0;
      first_y_read  <= '0;
      second_x_read <= '0;
    end else if (upd) begin
      phase         <= phase_next;
      attempt_count <= attempt_next;
      if (s2_pen && in_window) begin
        if (phase == tpf_pkg::PH_X1) first_x_read  <= val_rd;
        if (phase == tpf_pkg::PH_Y1) first_y_read  <= val_rd;
        if (phase == tpf_pkg::PH_X2) second_x_read <= val_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_status <= stat_next;
      s3_axis   <= phase_next[0];
      s3_avg_x  <= sum_x[tpf_pkg::READ_W:1];
      s3_avg_y  <= sum_y[tpf_pkg::READ_W:1];
    end
  end

  // ---------------- stage 4: calibration ----------------
  // coord = ((avg * gain) >>> 16) + shift, low 16 bits
  logic signed [MUL_W-1:0]     prod_x, prod_y;
  logic [tpf_pkg::COORD_W-1:0] cal_x, cal_y;
  logic                        ready_pt;

  assign prod_x = $signed(MUL_W'(s3_avg_x)) *
                  $signed({{tpf_pkg::GAIN_W{x_gain[tpf_pkg::GAIN_W-1]}}, x_gain});
  assign prod_y = $signed(MUL_W'(s3_avg_y)) *
                  $signed({{tpf_pkg::GAIN_W{y_gain[tpf_pkg::GAIN_W-1]}}, y_gain});
  assign cal_x    = prod_x[MUL_W-1:tpf_pkg::GAIN_W] + x_shift;
  assign cal_y    = prod_y[MUL_W-1:tpf_pkg::GAIN_W] + y_shift;
  assign ready_pt = (s3_status == tpf_pkg::STAT_READY);

  always_ff @(posedge clk) begin
    if (en_o) begin
      status    <= s3_status;
      next_axis <= s3_axis;
      point_x   <= ready_pt ? cal_x : '0;
      point_y   <= ready_pt ? cal_y : '0;
    end
  end

endmodule
